// File: sv/efhp_pkg.sv
// Types, codes and constants shared by the header parser modules.
// No dependencies.
package efhp_pkg;

	// Fixed part of the header: magic, version, kdf, chunk size, salt length
	localparam int MAGIC_LEN = 6;
	localparam int FIXED_LEN = 6 + 2 + 1 + 4 + 2;

	// Event queue between parser front and output back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SALT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_NONCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME  = 3'd5;
	localparam int CFG_DATA_W = 48;

	// Register reset values
	localparam logic [47:0] RST_MAGIC     = 48'd0;
	localparam logic [15:0] RST_VERSION   = 16'd1;
	localparam logic [31:0] RST_MAX_CHUNK = 32'(64 * 1024 * 1024);
	localparam logic [15:0] RST_MAX_SALT  = 16'd1024;
	localparam logic [15:0] RST_MAX_NONCE = 16'd64;
	localparam logic [15:0] RST_MAX_NAME  = 16'd4096;

	typedef enum logic [2:0] {
		PH_FIXED,
		PH_SALT,
		PH_NLEN,
		PH_NONCE,
		PH_MLEN,
		PH_NAME
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SALT,
		KIND_NONCE,
		KIND_NAME,
		KIND_STATUS
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK,
		ST_SMALL,
		ST_MAGIC,
		ST_VERSION,
		ST_CHUNK,
		ST_SALT_LARGE,
		ST_SALT_TRUNC,
		ST_NONCE_LARGE,
		ST_NONCE_TRUNC,
		ST_NAME_LARGE,
		ST_NAME_TRUNC
	} status_t;

	typedef struct packed {
		logic [47:0] magic_value;
		logic [15:0] expected_version;
		logic [31:0] max_chunk;
		logic [15:0] max_salt;
		logic [15:0] max_nonce;
		logic [15:0] max_name;
	} cfg_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [3:0]  status;
		logic [15:0] version;
		logic [7:0]  kdf_id;
		logic [31:0] chunk_size;
		logic [15:0] salt_length;
		logic [15:0] nonce_length;
		logic [15:0] name_length;
	} out_item_t;

	// One parsed byte: an optional payload request and an optional status request
	typedef struct packed {
		logic        has_pay;
		logic        has_stat;
		kind_t       pay_kind;
		logic [7:0]  pay_byte;
		status_t     code;
		logic [15:0] version;
		logic [7:0]  kdf;
		logic [31:0] chunk;
		logic [15:0] salt_len;
		logic [15:0] nonce_len;
		logic [15:0] name_len;
	} ev_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// File: sv/encrypted_file_header_parser.sv
// Top level of the encrypted file header parser: config registers, front, queue, back.
// Depends on efhp_pkg, efhp_front, efhp_queue and efhp_back.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | sink      | in_valid / in_ready   | in_item (byte_value, is_last)
//  out     | source    | out_valid / out_ready | out_item (kind .. name_length)
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One header byte is taken per cycle while the queue has room; it is parsed in the
// cycle it is accepted. Results leave the back register at one per cycle while
// out_ready is high; a byte that yields a payload and a status holds it until both go.
// A four-entry event queue lets the front keep taking bytes while out_ready is low;
// in_ready drops only when that queue is full.
// Reset is asynchronous and clears parser and queue state at once; no clearing pass.
// cfg_ready is always high; registers take effect on the next byte.
module encrypted_file_header_parser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  efhp_pkg::in_item_t                   in_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output efhp_pkg::out_item_t                  out_item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [efhp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [efhp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	efhp_pkg::cfg_t    cfg_q;
	efhp_pkg::ev_t     ev;
	efhp_pkg::ev_t     head;
	efhp_pkg::q_stat_t qst;
	logic              ev_push;
	logic              pop;
	logic              in_fire;

	// Config registers, masked to width on write; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_value      <= efhp_pkg::RST_MAGIC;
			cfg_q.expected_version <= efhp_pkg::RST_VERSION;
			cfg_q.max_chunk        <= efhp_pkg::RST_MAX_CHUNK;
			cfg_q.max_salt         <= efhp_pkg::RST_MAX_SALT;
			cfg_q.max_nonce        <= efhp_pkg::RST_MAX_NONCE;
			cfg_q.max_name         <= efhp_pkg::RST_MAX_NAME;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				efhp_pkg::CFG_MAGIC:     cfg_q.magic_value      <= cfg_data;
				efhp_pkg::CFG_VERSION:   cfg_q.expected_version <= cfg_data[15:0];
				efhp_pkg::CFG_MAX_CHUNK: cfg_q.max_chunk        <= cfg_data[31:0];
				efhp_pkg::CFG_MAX_SALT:  cfg_q.max_salt         <= cfg_data[15:0];
				efhp_pkg::CFG_MAX_NONCE: cfg_q.max_nonce        <= cfg_data[15:0];
				efhp_pkg::CFG_MAX_NAME:  cfg_q.max_name         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Front takes a byte whenever the queue has room for its event.
	assign in_ready = !qst.full;
	assign in_fire  = in_valid && in_ready;

	efhp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_item (in_item),
		.cfg     (cfg_q),
		.ev      (ev),
		.ev_push (ev_push)
	);

	efhp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.push_data (ev),
		.pop       (pop),
		.head      (head),
		.qst       (qst)
	);

	efhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (qst.empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Payload requests never carry status or decoded header fields.
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind != efhp_pkg::KIND_STATUS |->
			out_item.status == efhp_pkg::ST_OK && out_item.chunk_size == '0 &&
			out_item.version == '0)
		else $error("payload request carries status fields");

	// Every queued event carries at least one request.
	a_event_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ev_push |-> ev.has_pay || ev.has_stat)
		else $error("empty event pushed");

	// With events queued, the output register holds a valid request in the next cycle.
	a_back_loads: assert property (@(posedge clk) disable iff (!arst_n)
		!qst.empty |=> out_valid)
		else $error("back idle with events queued");

	// No push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qst.full |-> !ev_push)
		else $error("event queue overflow");

endmodule

// File: sv/efhp_front.sv
// Parser front: walks the header byte by byte and emits at most one event per byte.
// Depends on efhp_pkg.
module efhp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  efhp_pkg::in_item_t in_item,
	input  efhp_pkg::cfg_t    cfg,
	output efhp_pkg::ev_t     ev,
	output logic              ev_push
);

	efhp_pkg::phase_t  phase_q, phase_d;
	efhp_pkg::status_t perr_q, perr_d;
	logic [3:0]  pos_q, pos_d;
	logic [15:0] fc_q, fc_d;
	logic [15:0] ver_q, ver_d;
	logic [7:0]  kdf_q, kdf_d;
	logic [31:0] chunk_q, chunk_d;
	logic [15:0] slen_q, slen_d;
	logic [15:0] nlen_q, nlen_d;
	logic [15:0] mlen_q, mlen_d;
	logic        done_q, done_d;

	always_comb begin
		logic [7:0]  b;
		logic [7:0]  want;
		logic [15:0] len;
		logic [15:0] fc_dec;
		logic        stat;
		efhp_pkg::status_t err;
		efhp_pkg::status_t sc;

		b       = in_item.byte_value;
		want    = 8'(cfg.magic_value >> {pos_q[2:0], 3'b000});
		len     = {b, fc_q[7:0]};
		fc_dec  = fc_q - 16'd1;
		stat    = 1'b0;
		err     = efhp_pkg::ST_OK;
		sc      = efhp_pkg::ST_OK;

		phase_d = phase_q;
		perr_d  = perr_q;
		pos_d   = pos_q;
		fc_d    = fc_q;
		ver_d   = ver_q;
		kdf_d   = kdf_q;
		chunk_d = chunk_q;
		slen_d  = slen_q;
		nlen_d  = nlen_q;
		mlen_d  = mlen_q;
		done_d  = done_q;
		ev      = '0;

		if (!done_q) begin
			case (phase_q)
				efhp_pkg::PH_FIXED: begin
					case (pos_q)
						4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
							if (b != want && perr_q == efhp_pkg::ST_OK)
								perr_d = efhp_pkg::ST_MAGIC;
						end
						4'd6:  ver_d[7:0]     = b;
						4'd7:  ver_d[15:8]    = b;
						4'd8:  kdf_d          = b;
						4'd9:  chunk_d[7:0]   = b;
						4'd10: chunk_d[15:8]  = b;
						4'd11: chunk_d[23:16] = b;
						4'd12: chunk_d[31:24] = b;
						4'd13: slen_d[7:0]    = b;
						default: slen_d[15:8] = b;
					endcase
					if (pos_q >= 4'(efhp_pkg::FIXED_LEN - 1)) begin
						// all early checks resolve on the last fixed byte, in priority order
						err = perr_d;
						if (err == efhp_pkg::ST_OK && ver_d != cfg.expected_version)
							err = efhp_pkg::ST_VERSION;
						if (err == efhp_pkg::ST_OK && (chunk_d == '0 || chunk_d > cfg.max_chunk))
							err = efhp_pkg::ST_CHUNK;
						if (err == efhp_pkg::ST_OK && slen_d > cfg.max_salt)
							err = efhp_pkg::ST_SALT_LARGE;
						pos_d = '0;
						if (err != efhp_pkg::ST_OK) begin
							stat   = 1'b1;
							sc     = err;
							done_d = 1'b1;
						end else if (slen_d != '0) begin
							phase_d = efhp_pkg::PH_SALT;
							fc_d    = slen_d;
						end else begin
							phase_d = efhp_pkg::PH_NLEN;
						end
					end else begin
						pos_d = pos_q + 4'd1;
					end
				end
				efhp_pkg::PH_SALT, efhp_pkg::PH_NONCE, efhp_pkg::PH_NAME: begin
					ev.has_pay  = 1'b1;
					ev.pay_byte = b;
					case (phase_q)
						efhp_pkg::PH_SALT:  ev.pay_kind = efhp_pkg::KIND_SALT;
						efhp_pkg::PH_NONCE: ev.pay_kind = efhp_pkg::KIND_NONCE;
						default:            ev.pay_kind = efhp_pkg::KIND_NAME;
					endcase
					fc_d = fc_dec;
					if (fc_dec == '0) begin
						pos_d = '0;
						case (phase_q)
							efhp_pkg::PH_SALT:  phase_d = efhp_pkg::PH_NLEN;
							efhp_pkg::PH_NONCE: phase_d = efhp_pkg::PH_MLEN;
							default: begin
								stat   = 1'b1;
								sc     = efhp_pkg::ST_OK;
								done_d = 1'b1;
							end
						endcase
					end
				end
				efhp_pkg::PH_NLEN, efhp_pkg::PH_MLEN: begin
					if (pos_q == '0) begin
						fc_d  = {8'd0, b};
						pos_d = 4'd1;
					end else begin
						pos_d = '0;
						if (phase_q == efhp_pkg::PH_NLEN) begin
							nlen_d = len;
							if (len > cfg.max_nonce) begin
								stat   = 1'b1;
								sc     = efhp_pkg::ST_NONCE_LARGE;
								done_d = 1'b1;
							end else if (len != '0) begin
								fc_d    = len;
								phase_d = efhp_pkg::PH_NONCE;
							end else begin
								fc_d    = '0;
								phase_d = efhp_pkg::PH_MLEN;
							end
						end else begin
							mlen_d = len;
							if (len > cfg.max_name) begin
								stat   = 1'b1;
								sc     = efhp_pkg::ST_NAME_LARGE;
								done_d = 1'b1;
							end else if (len != '0) begin
								fc_d    = len;
								phase_d = efhp_pkg::PH_NAME;
							end else begin
								fc_d   = '0;
								stat   = 1'b1;
								sc     = efhp_pkg::ST_OK;
								done_d = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end

		// end of buffer before the header finished: report by phase
		if (in_item.is_last && !done_d) begin
			stat = 1'b1;
			case (phase_d)
				efhp_pkg::PH_FIXED: sc = efhp_pkg::ST_SMALL;
				efhp_pkg::PH_SALT:  sc = efhp_pkg::ST_SALT_TRUNC;
				efhp_pkg::PH_NONCE: sc = efhp_pkg::ST_NONCE_TRUNC;
				efhp_pkg::PH_NAME:  sc = efhp_pkg::ST_NAME_TRUNC;
				default:            sc = efhp_pkg::ST_OK;
			endcase
		end

		ev.has_stat  = stat;
		ev.code      = sc;
		ev.version   = ver_d;
		ev.kdf       = kdf_d;
		ev.chunk     = chunk_d;
		ev.salt_len  = slen_d;
		ev.nonce_len = nlen_d;
		ev.name_len  = mlen_d;

		if (in_item.is_last) begin
			phase_d = efhp_pkg::PH_FIXED;
			perr_d  = efhp_pkg::ST_OK;
			pos_d   = '0;
			fc_d    = '0;
			ver_d   = '0;
			kdf_d   = '0;
			chunk_d = '0;
			slen_d  = '0;
			nlen_d  = '0;
			mlen_d  = '0;
			done_d  = 1'b0;
		end
	end

	assign ev_push = in_fire && (ev.has_pay || ev.has_stat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= efhp_pkg::PH_FIXED;
			perr_q  <= efhp_pkg::ST_OK;
			pos_q   <= '0;
			fc_q    <= '0;
			ver_q   <= '0;
			kdf_q   <= '0;
			chunk_q <= '0;
			slen_q  <= '0;
			nlen_q  <= '0;
			mlen_q  <= '0;
			done_q  <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			perr_q  <= perr_d;
			pos_q   <= pos_d;
			fc_q    <= fc_d;
			ver_q   <= ver_d;
			kdf_q   <= kdf_d;
			chunk_q <= chunk_d;
			slen_q  <= slen_d;
			nlen_q  <= nlen_d;
			mlen_q  <= mlen_d;
			done_q  <= done_d;
		end
	end

endmodule

// File: sv/efhp_queue.sv
// Small event FIFO between the parser front and the output back.
// Depends on efhp_pkg.
module efhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  efhp_pkg::ev_t     push_data,
	input  logic              pop,
	output efhp_pkg::ev_t     head,
	output efhp_pkg::q_stat_t qst
);

	efhp_pkg::ev_t mem_q [efhp_pkg::QDEPTH];
	logic [efhp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [efhp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [efhp_pkg::QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + efhp_pkg::QCNT_W'(push) - efhp_pkg::QCNT_W'(pop);
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign qst.empty = (cnt_q == '0);
	assign qst.full  = (cnt_q == efhp_pkg::QCNT_W'(efhp_pkg::QDEPTH));

endmodule

// File: sv/efhp_back.sv
// Output back: expands each event into one or two result requests.
// Depends on efhp_pkg.
module efhp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  efhp_pkg::ev_t       head,
	input  logic                q_empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output efhp_pkg::out_item_t out_item
);

	efhp_pkg::ev_t cur_q;
	logic          cur_vld_q;
	logic          pay_pend_q;
	logic          done;
	logic          load;

	// event finishes when its last request is taken
	assign done = cur_vld_q && out_ready && !(pay_pend_q && cur_q.has_stat);
	assign load = !cur_vld_q || done;
	assign pop  = load && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q  <= 1'b0;
			pay_pend_q <= 1'b0;
		end else if (load) begin
			cur_vld_q  <= !q_empty;
			pay_pend_q <= !q_empty && head.has_pay;
		end else if (out_ready) begin
			pay_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

	assign out_valid = cur_vld_q;

	always_comb begin
		out_item = '0;
		if (pay_pend_q) begin
			out_item.kind      = cur_q.pay_kind;
			out_item.data_byte = cur_q.pay_byte;
		end else begin
			out_item.kind         = efhp_pkg::KIND_STATUS;
			out_item.status       = cur_q.code;
			out_item.version      = cur_q.version;
			out_item.kdf_id       = cur_q.kdf;
			out_item.chunk_size   = cur_q.chunk;
			out_item.salt_length  = cur_q.salt_len;
			out_item.nonce_length = cur_q.nonce_len;
			out_item.name_length  = cur_q.name_len;
		end
	end

endmodule
